>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files; only the decoder includes them.
// Depends on nothing; the checks drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/hpack_pkg.sv
// Package for the HPACK Huffman decoder: item types, status codes, FSM states
// and the canonical code tables worked out at elaboration. Depends on nothing.
package hpack_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int MAX_CODE_LEN   = 30;

  // End-of-string status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_SHORT     = 2'd2;

  // Result kinds.
  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_END    = 1'b1;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  decoded_byte;
    logic [1:0]  end_status;
    logic [15:0] decoded_count;
    logic        last_result;
  } out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BITS,
    S_FINISH
  } state_t;

  typedef int unsigned sym_int_arr_t [256];
  typedef logic [29:0] first_arr_t [32];
  typedef logic [8:0]  num_arr_t [32];
  typedef logic [7:0]  sym_arr_t [256];

  // Code values of the 256 octets, right aligned.
  localparam sym_int_arr_t CODE_VAL = '{
    'h1ff8,'h7fffd8,'hfffffe2,'hfffffe3,'hfffffe4,'hfffffe5,'hfffffe6,'hfffffe7,
    'hfffffe8,'hffffea,'h3ffffffc,'hfffffe9,'hfffffea,'h3ffffffd,'hfffffeb,'hfffffec,
    'hfffffed,'hfffffee,'hfffffef,'hffffff0,'hffffff1,'hffffff2,'h3ffffffe,'hffffff3,
    'hffffff4,'hffffff5,'hffffff6,'hffffff7,'hffffff8,'hffffff9,'hffffffa,'hffffffb,
    'h14,'h3f8,'h3f9,'hffa,'h1ff9,'h15,'hf8,'h7fa,'h3fa,'h3fb,'hf9,'h7fb,'hfa,'h16,'h17,'h18,
    'h0,'h1,'h2,'h19,'h1a,'h1b,'h1c,'h1d,'h1e,'h1f,'h5c,'hfb,'h7ffc,'h20,'hffb,'h3fc,
    'h1ffa,'h21,'h5d,'h5e,'h5f,'h60,'h61,'h62,'h63,'h64,'h65,'h66,'h67,'h68,'h69,'h6a,
    'h6b,'h6c,'h6d,'h6e,'h6f,'h70,'h71,'h72,'hfc,'h73,'hfd,'h1ffb,'h7fff0,'h1ffc,'h3ffc,'h22,
    'h7ffd,'h3,'h23,'h4,'h24,'h5,'h25,'h26,'h27,'h6,'h74,'h75,'h28,'h29,'h2a,'h7,
    'h2b,'h76,'h2c,'h8,'h9,'h2d,'h77,'h78,'h79,'h7a,'h7b,'h7ffe,'h7fc,'h3ffd,'h1ffd,'hffffffc,
    'hfffe6,'h3fffd2,'hfffe7,'hfffe8,'h3fffd3,'h3fffd4,'h3fffd5,'h7fffd9,
    'h3fffd6,'h7fffda,'h7fffdb,'h7fffdc,'h7fffdd,'h7fffde,'hffffeb,'h7fffdf,
    'hffffec,'hffffed,'h3fffd7,'h7fffe0,'hffffee,'h7fffe1,'h7fffe2,'h7fffe3,
    'h7fffe4,'h1fffdc,'h3fffd8,'h7fffe5,'h3fffd9,'h7fffe6,'h7fffe7,'hffffef,
    'h3fffda,'h1fffdd,'hfffe9,'h3fffdb,'h3fffdc,'h7fffe8,'h7fffe9,'h1fffde,
    'h7fffea,'h3fffdd,'h3fffde,'hfffff0,'h1fffdf,'h3fffdf,'h7fffeb,'h7fffec,
    'h1fffe0,'h1fffe1,'h3fffe0,'h1fffe2,'h7fffed,'h3fffe1,'h7fffee,'h7fffef,
    'hfffea,'h3fffe2,'h3fffe3,'h3fffe4,'h7ffff0,'h3fffe5,'h3fffe6,'h7ffff1,
    'h3ffffe0,'h3ffffe1,'hfffeb,'h7fff1,'h3fffe7,'h7ffff2,'h3fffe8,'h1ffffec,
    'h3ffffe2,'h3ffffe3,'h3ffffe4,'h7ffffde,'h7ffffdf,'h3ffffe5,'hfffff1,'h1ffffed,
    'h7fff2,'h1fffe3,'h3ffffe6,'h7ffffe0,'h7ffffe1,'h3ffffe7,'h7ffffe2,'hfffff2,
    'h1fffe4,'h1fffe5,'h3ffffe8,'h3ffffe9,'hffffffd,'h7ffffe3,'h7ffffe4,'h7ffffe5,
    'hfffec,'hfffff3,'hfffed,'h1fffe6,'h3fffe9,'h1fffe7,'h1fffe8,'h7ffff3,
    'h3fffea,'h3fffeb,'h1ffffee,'h1ffffef,'hfffff4,'hfffff5,'h3ffffea,'h7ffff4,
    'h3ffffeb,'h7ffffe6,'h3ffffec,'h3ffffed,'h7ffffe7,'h7ffffe8,'h7ffffe9,'h7ffffea,
    'h7ffffeb,'hffffffe,'h7ffffec,'h7ffffed,'h7ffffee,'h7ffffef,'h7fffff0,'h3ffffee
  };

  // Code lengths of the 256 octets.
  localparam sym_int_arr_t CODE_LEN = '{
    13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
    28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
    6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
    5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
    13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
    7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
    15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
    6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
    20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
    24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
    22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
    21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
    26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
    19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
    20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
    26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26
  };

  // Smallest code of each length; zero where a length has no codes.
  function automatic first_arr_t calc_first();
    first_arr_t  f;
    int unsigned best;
    for (int l = 0; l < 32; l++) begin
      best = 32'hffff_ffff;
      for (int s = 0; s < 256; s++) begin
        if (CODE_LEN[s] == l && CODE_VAL[s] < best) best = CODE_VAL[s];
      end
      f[l] = (best == 32'hffff_ffff) ? 30'd0 : best[29:0];
    end
    return f;
  endfunction

  // Number of codes of each length.
  function automatic num_arr_t calc_count();
    num_arr_t c;
    int       n;
    for (int l = 0; l < 32; l++) begin
      n = 0;
      for (int s = 0; s < 256; s++) begin
        if (CODE_LEN[s] == l) n++;
      end
      c[l] = 9'(n);
    end
    return c;
  endfunction

  // Position in the sorted symbol list of the first code of each length.
  function automatic num_arr_t calc_offset();
    num_arr_t o;
    num_arr_t c;
    int       run;
    c   = calc_count();
    run = 0;
    for (int l = 0; l < 32; l++) begin
      o[l] = 9'(run);
      run  = run + int'(c[l]);
    end
    return o;
  endfunction

  // Octets ordered by length, then by code value.
  function automatic sym_arr_t calc_sorted();
    sym_arr_t   t;
    first_arr_t f;
    num_arr_t   o;
    int         idx;
    f = calc_first();
    o = calc_offset();
    for (int s = 0; s < 256; s++) begin
      idx = int'(o[CODE_LEN[s]]) + int'(CODE_VAL[s]) - int'(f[CODE_LEN[s]]);
      t[idx[7:0]] = 8'(s);
    end
    return t;
  endfunction

  localparam first_arr_t CODE_FIRST  = calc_first();
  localparam num_arr_t   CODE_COUNT  = calc_count();
  localparam num_arr_t   CODE_OFFSET = calc_offset();
  localparam sym_arr_t   CODE_SYM    = calc_sorted();

endpackage

>>> hw/rtl/hpack_huffman_decoder.sv
// HPACK Huffman string decoder, bit-serial canonical code walk.
// Depends on hpack_pkg and assert_macros.svh.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | in_data   (coded_byte, final_byte)
//  out     | output    | out_valid/out_stall | out_data  (symbol or end-of-string item)
//  cfg     | input     | cfg_we              | cfg_data  (output_limit)
//
// An item is loaded in S_IDLE and then walked in eight bit steps in S_BITS; a final
// byte adds an S_FINISH step for the end-of-string item.
// The shift register of the coded byte advances one bit per cycle through the
// length/first-code compare; a step waits while the output register is full and stalled.
// Reset is synchronous and clears the string state and sets output_limit to 65535.
module hpack_huffman_decoder
  import hpack_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
`include "assert_macros.svh"

  state_t                  state, state_next;
  logic [15:0]             output_limit;
  logic [7:0]              shift, shift_next;
  logic [2:0]              bit_cnt, bit_cnt_next;
  logic                    fin, fin_next;
  logic [29:0]             code, code_next;
  logic [4:0]              code_len, code_len_next;
  logic [1:0]              err, err_next;
  logic [COUNT_BITS-1:0]   count, count_next;
  logic                    emit;
  out_t                    emit_data;
  logic                    slot_free;

  // Decode datapath signals.
  logic [29:0]             ncode;
  logic [4:0]              nlen;
  logic [29:0]             diff;
  logic                    hit;
  logic [7:0]              sym;
  logic                    at_limit;
  logic [COUNT_BITS+15:0]  cnt_w, lim_w;
  logic [7:0]              ones;
  logic [1:0]              end_status;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  // One-bit extension of the current code and its table lookup.
  assign ncode    = {code[28:0], shift[7]};
  assign nlen     = code_len + 5'd1;
  assign diff     = ncode - CODE_FIRST[nlen];
  assign hit      = diff < {21'd0, CODE_COUNT[nlen]};
  assign sym      = CODE_SYM[CODE_OFFSET[nlen][7:0] + diff[7:0]];
  assign cnt_w    = {16'd0, count};
  assign lim_w    = {{COUNT_BITS{1'b0}}, output_limit};
  assign at_limit = (cnt_w >= lim_w) || (count == {COUNT_BITS{1'b1}});

  // Padding must be at most seven bits, all ones.
  assign ones = 8'((9'd1 << code_len[2:0]) - 9'd1);
  always_comb begin
    if (err != ST_OK) begin
      end_status = err;
    end else if (code_len > 5'd7 || code[7:0] != ones) begin
      end_status = ST_MALFORMED;
    end else begin
      end_status = ST_OK;
    end
  end

  // Next state and datapath updates.
  always_comb begin
    state_next    = state;
    shift_next    = shift;
    bit_cnt_next  = bit_cnt;
    fin_next      = fin;
    code_next     = code;
    code_len_next = code_len;
    err_next      = err;
    count_next    = count;
    emit          = 1'b0;
    emit_data     = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          shift_next   = in_data.coded_byte;
          fin_next     = in_data.final_byte;
          bit_cnt_next = 3'd0;
          state_next   = S_BITS;
        end
      end
      S_BITS: begin
        if (slot_free) begin
          if (err == ST_OK) begin
            if (hit) begin
              if (at_limit) begin
                err_next = ST_SHORT;
              end else begin
                emit                   = 1'b1;
                emit_data.result_kind  = KIND_SYMBOL;
                emit_data.decoded_byte = sym;
                count_next             = count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
                code_next              = '0;
                code_len_next          = '0;
              end
            end else if (nlen == 5'(MAX_CODE_LEN)) begin
              // The all-ones path of full length has no symbol.
              err_next = ST_MALFORMED;
            end else begin
              code_next     = ncode;
              code_len_next = nlen;
            end
          end
          shift_next   = {shift[6:0], 1'b0};
          bit_cnt_next = bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            state_next = fin ? S_FINISH : S_IDLE;
          end
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          emit                    = 1'b1;
          emit_data.result_kind   = KIND_END;
          emit_data.end_status    = end_status;
          emit_data.decoded_count = cnt_w[15:0];
          emit_data.last_result   = 1'b1;
          code_next               = '0;
          code_len_next           = '0;
          err_next                = ST_OK;
          count_next              = '0;
          state_next              = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // String state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      code         <= '0;
      code_len     <= '0;
      err          <= ST_OK;
      count        <= '0;
      output_limit <= 16'hffff;
      out_valid    <= 1'b0;
    end else begin
      code     <= code_next;
      code_len <= code_len_next;
      err      <= err_next;
      count    <= count_next;
      if (cfg_we) begin
        output_limit <= cfg_data;
      end
      if (slot_free) begin
        out_valid <= emit;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    shift   <= shift_next;
    bit_cnt <= bit_cnt_next;
    fin     <= fin_next;
    if (emit) begin
      out_data <= emit_data;
    end
  end

  // Checks on the control logic.
  `ASSERT_IMPLIES(a_accept_idle, clk, rst, in_valid && !in_stall, state == S_IDLE)
  `ASSERT_IMPLIES(a_len_range, clk, rst, 1'b1, code_len < 5'(MAX_CODE_LEN))
  `ASSERT_NEXT(a_end_clears, clk, rst, state == S_FINISH && slot_free,
               code_len == 5'd0 && err == ST_OK && state == S_IDLE)
  `ASSERT_IMPLIES(a_emit_slot, clk, rst, emit, slot_free)

endmodule

>>> tb/hpack_huffman_decoder_tb.sv
// Self-checking testbench for the HPACK Huffman string decoder.
// Depends on hpack_pkg for the item types and status codes, and on the RTL.
// A local code tree predicts every symbol and end-of-string item the block emits.
module hpack_huffman_decoder_tb;
  import hpack_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODE_COUNT  = 512;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 30;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  // Code book and decode tree, rebuilt here from the code lengths alone.
  int unsigned code_length [256];
  int unsigned code_word [256];
  int          branch [NODE_COUNT][2];
  bit          is_leaf [NODE_COUNT];
  logic [7:0]  leaf_octet [NODE_COUNT];

  // Predicted decoder state and register.
  int unsigned limit_now;
  int unsigned walk_node;
  int unsigned bits_pending;
  bit          pad_ones;
  logic [1:0]  error_held;
  int unsigned octets_out;

  out_t        expected_q [$];
  int          fail_count = 0;
  int          items_sent = 0;
  int unsigned cycle_count = 0;
  bit          idling_on = 1'b1;
  int          hold_request = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  hpack_huffman_decoder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Canonical code: codes of one length are consecutive in octet order.
  task automatic build_code_book();
    int unsigned lens [256] = '{
      13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
      28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
      6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
      5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
      13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
      7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
      15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
      6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
      20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
      24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
      22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
      21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
      26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
      19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
      20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
      26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26};
    int unsigned next_code;
    int unsigned used;
    int unsigned node;
    int unsigned b;
    next_code = 0;
    for (int l = 1; l <= 30; l++) begin
      for (int s = 0; s < 256; s++) begin
        if (lens[s] == l) begin
          code_word[s] = next_code;
          next_code++;
        end
      end
      next_code = next_code << 1;
    end
    code_length = lens;
    for (int n = 0; n < NODE_COUNT; n++) begin
      branch[n][0] = 0;
      branch[n][1] = 0;
      is_leaf[n] = 1'b0;
      leaf_octet[n] = '0;
    end
    used = 1;
    for (int s = 0; s < 256; s++) begin
      node = 0;
      for (int i = 0; i < code_length[s]; i++) begin
        b = (code_word[s] >> (code_length[s] - 1 - i)) & 1;
        if (branch[node][b] == 0) begin
          branch[node][b] = used;
          used++;
        end
        node = branch[node][b];
      end
      is_leaf[node] = 1'b1;
      leaf_octet[node] = 8'(s);
    end
  endtask

  function automatic void clear_string_state();
    walk_node = 0;
    bits_pending = 0;
    pad_ones = 1'b1;
    error_held = ST_OK;
    octets_out = 0;
  endfunction

  // Walk one coded byte through the tree and queue the items it should cause.
  function automatic void decode_coded_byte(logic [7:0] octet, logic last);
    out_t        r;
    int unsigned b;
    int unsigned nxt;
    for (int i = 0; i < 8; i++) begin
      b = octet[7 - i];
      if (error_held != ST_OK) break;
      nxt = branch[walk_node][b];
      if (nxt == 0) begin
        error_held = ST_MALFORMED;
        break;
      end
      walk_node = nxt;
      if (bits_pending < 31) bits_pending++;
      pad_ones = pad_ones & b[0];
      if (is_leaf[nxt]) begin
        if (octets_out >= limit_now || octets_out >= 65535) begin
          error_held = ST_SHORT;
          break;
        end
        r = '0;
        r.result_kind = KIND_SYMBOL;
        r.decoded_byte = leaf_octet[nxt];
        expected_q.push_back(r);
        octets_out++;
        walk_node = 0;
        bits_pending = 0;
        pad_ones = 1'b1;
      end
    end
    if (last) begin
      r = '0;
      r.result_kind = KIND_END;
      r.end_status = error_held;
      if (error_held == ST_OK && (bits_pending > 7 || !pad_ones)) r.end_status = ST_MALFORMED;
      r.decoded_count = 16'(octets_out);
      r.last_result = 1'b1;
      expected_q.push_back(r);
      clear_string_state();
    end
  endfunction

  // Offer one item, with a random gap first while idling is on, and predict it once accepted.
  // Valid stays high after the item is taken until the next gap or wait.
  task automatic send_item(logic [7:0] octet, logic last);
    int gap;
    gap = (idling_on && $urandom_range(99) < 28) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.coded_byte <= octet;
    in_data.final_byte <= last;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
      @(posedge clk);
    end
    @(posedge clk);
    decode_coded_byte(octet, last);
    items_sent++;
  endtask

  // Huffman-code a list of octets and send it as one string.
  // Padding kinds: 0 proper ones, 1 a zero in the padding if there is any, 2 an extra byte of ones.
  task automatic send_string(logic [7:0] octets [$], int pad_kind);
    bit          bits [$];
    logic [7:0]  coded [$];
    logic [7:0]  acc;
    int unsigned s;
    foreach (octets[k]) begin
      s = octets[k];
      for (int i = code_length[s] - 1; i >= 0; i--) bits.push_back(code_word[s][i]);
    end
    if (bits.size() % 8 != 0) begin
      if (pad_kind == 1) bits.push_back(1'b0);
      while (bits.size() % 8 != 0) bits.push_back(1'b1);
    end
    for (int i = 0; i < bits.size(); i += 8) begin
      for (int j = 0; j < 8; j++) acc[7 - j] = bits[i + j];
      coded.push_back(acc);
    end
    if (pad_kind == 2 || coded.size() == 0) coded.push_back(8'hff);
    foreach (coded[k]) send_item(coded[k], k == coded.size() - 1);
  endtask

  // Wait for every expected item, let the block settle, then write the limit.
  task automatic write_output_limit(logic [15:0] value);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_now = value;
  endtask

  function automatic logic [7:0] pick_octet();
    logic [7:0] o;
    o = 8'($urandom_range(255));
    if ($urandom_range(99) < 75) begin
      while (code_length[o] > 8) o = 8'($urandom_range(255));
    end
    return o;
  endfunction

  // Receiver: random stalls while idling is on, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_request != hold_served) begin
      hold_served <= hold_request;
      hold_left <= 200;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idling_on && ($urandom_range(99) < 28);
    end
  end

  // Each item taken at the next edge is compared with the oldest expectation.
  always @(negedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected item: %h", out_data);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_data.result_kind !== want.result_kind) begin
          $error("result_kind: expected %0d, got %0d", want.result_kind, out_data.result_kind);
          fail_count++;
        end
        if (out_data.decoded_byte !== want.decoded_byte) begin
          $error("decoded_byte: expected %0d, got %0d", want.decoded_byte,
                 out_data.decoded_byte);
          fail_count++;
        end
        if (out_data.end_status !== want.end_status) begin
          $error("end_status: expected %0d, got %0d", want.end_status, out_data.end_status);
          fail_count++;
        end
        if (out_data.decoded_count !== want.decoded_count) begin
          $error("decoded_count: expected %0d, got %0d", want.decoded_count,
                 out_data.decoded_count);
          fail_count++;
        end
        if (out_data.last_result !== want.last_result) begin
          $error("last_result: expected %0d, got %0d", want.last_result, out_data.last_result);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Short strings covering the code extremes, the padding rules and the limit.
  task automatic test_directed();
    send_string('{8'h77, 8'h77, 8'h77, 8'h2e, 8'h65, 8'h78, 8'h61}, 0);
    send_string('{8'h00, 8'hff, 8'h0a, 8'h0d, 8'h16}, 0);
    send_string('{8'h30}, 1);
    send_string('{8'h61, 8'h61}, 2);
    // The all-ones end-of-string path has no leaf and must be rejected.
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b1);
    send_item(8'h00, 1'b1);
    send_item(8'hff, 1'b1);
    write_output_limit(16'd0);
    send_string('{8'h31, 8'h32}, 0);
    write_output_limit(16'd1);
    send_string('{8'h31, 8'h32, 8'h33}, 0);
    write_output_limit(16'd65535);
  endtask

  // Mostly well-formed strings of random octets, some broken ones and raw noise.
  task automatic test_random(int item_goal);
    logic [7:0] octets [$];
    int         len;
    int         pick;
    while (items_sent < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++) send_item(8'($urandom_range(255)), i == len - 1);
      end else begin
        octets.delete();
        len = $urandom_range(10);
        for (int i = 0; i < len; i++) octets.push_back(pick_octet());
        send_string(octets, (pick < 80) ? 0 : (pick < 90 ? 1 : 2));
      end
      if ($urandom_range(9) == 0) write_output_limit(16'($urandom_range(6)));
      else if ($urandom_range(9) == 0) write_output_limit(16'd65535);
    end
  endtask

  // Receiver holds off while strings keep coming, so the input must stall.
  task automatic test_backpressure();
    logic [7:0] octets [$];
    idling_on = 1'b0;
    hold_request++;
    for (int k = 0; k < 3; k++) begin
      octets.delete();
      for (int i = 0; i < 6; i++) octets.push_back(pick_octet());
      send_string(octets, 0);
    end
    // Sender waits until every item has arrived before going on.
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    idling_on = 1'b1;
  endtask

  initial begin
    int unsigned drain;
    build_code_book();
    limit_now = 65535;
    clear_string_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(items_sent + 30);
    idling_on = 1'b0;
    test_random(items_sent + 20);
    idling_on = 1'b1;
    test_random(items_sent + 28);
    in_valid <= 1'b0;
    drain = 0;
    while (expected_q.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected items never arrived", expected_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/hpack_pkg.sv
hw/rtl/hpack_huffman_decoder.sv
tb/hpack_huffman_decoder_tb.sv
